// ===== rtl/cr2q_pkg.sv =====
// ----------------------------------------------------------------------------
// cr2q_pkg
// Shared types and operation codes for the reference-to-query position unit.
// ----------------------------------------------------------------------------
package cr2q_pkg;

  // Alignment operation codes. Codes above OP_DIFF move neither the distance nor the query count.
  localparam logic [3:0] OP_MATCH = 4'd0;
  localparam logic [3:0] OP_INS   = 4'd1;
  localparam logic [3:0] OP_DEL   = 4'd2;
  localparam logic [3:0] OP_SKIP  = 4'd3;
  localparam logic [3:0] OP_SOFT  = 4'd4;
  localparam logic [3:0] OP_HARD  = 4'd5;
  localparam logic [3:0] OP_PAD   = 4'd6;
  localparam logic [3:0] OP_EQUAL = 4'd7;
  localparam logic [3:0] OP_DIFF  = 4'd8;

  // One alignment operation as it enters the unit.
  typedef struct packed {
    logic [3:0]  code;
    logic [27:0] length;
    logic [30:0] target;
    logic [30:0] start;
    logic        first;
    logic        last;
  } op_t;

  // One resolved position.
  typedef struct packed {
    logic signed [31:0] query_pos;
    logic               is_deletion;
    logic               is_ref_skip;
    logic               covered;
  } res_t;

endpackage

// ===== rtl/cigar_ref_to_query_position_unit.sv =====
// Path: an accepted item waits in the input register, is walked by the
// combinational walk stage, and any result is registered in the result register.
// Throughput: one operation per cycle unless a full result register is stalled;
// the walk's single add-and-compare step on distance and query count sets this.
// Reset: asynchronous, active low; clears both pipeline registers' valid
// flags and the running distance, query count and done flag to zero.
// ----------------------------------------------------------------------------
// cigar_ref_to_query_position_unit
// Resolves a reference coordinate to a read's query coordinate by walking the
// read's alignment operations, one item per cycle unless the output stalls.
// ----------------------------------------------------------------------------
module cigar_ref_to_query_position_unit import cr2q_pkg::*; #(
  parameter int COORD_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [3:0]         op_code_i,
  input  logic [27:0]        op_length_i,
  input  logic [30:0]        target_position_i,
  input  logic [30:0]        read_start_i,
  input  logic               first_op_i,
  input  logic               last_op_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] query_pos_o,
  output logic               is_deletion_o,
  output logic               is_ref_skip_o,
  output logic               covered_o
);

  op_t  op_in, op_reg;
  logic op_valid;
  logic step;
  logic res_valid;
  res_t res_new, res_out;

  assign op_in.code   = op_code_i;
  assign op_in.length = op_length_i;
  assign op_in.target = target_position_i;
  assign op_in.start  = read_start_i;
  assign op_in.first  = first_op_i;
  assign op_in.last   = last_op_i;

  // The walk advances when the result register is free or being drained.
  assign step = op_valid && (!out_valid_o || !out_stall_i);

  cr2q_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .op_i       (op_in),
    .take_i     (step),
    .valid_o    (op_valid),
    .op_o       (op_reg)
  );

  cr2q_walk #(
    .COORD_BITS (COORD_BITS)
  ) u_walk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .op_i        (op_reg),
    .res_valid_o (res_valid),
    .res_o       (res_new)
  );

  cr2q_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_valid),
    .res_i       (res_new),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res_out)
  );

  assign query_pos_o   = res_out.query_pos;
  assign is_deletion_o = res_out.is_deletion;
  assign is_ref_skip_o = res_out.is_ref_skip;
  assign covered_o     = res_out.covered;

`ifndef SYNTHESIS
  // A new result is only written when the held one is free or leaving.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> (!out_valid_o || !out_stall_i))
    else $error("result register overwritten while stalled");

  // A reference skip is always reported as a deletion too.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_ref_skip_o) |-> is_deletion_o)
    else $error("reference skip without deletion flag");

  // Deletions are covered and carry a zero query position.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_deletion_o) |-> (covered_o && (query_pos_o == 32'sd0)))
    else $error("deletion result malformed");

  // An uncovered result carries no position and no deletion.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !covered_o) |-> ((query_pos_o == 32'sd0) && !is_deletion_o))
    else $error("uncovered result malformed");
`endif

endmodule

// ===== rtl/cr2q_in_reg.sv =====
// ----------------------------------------------------------------------------
// cr2q_in_reg
// Input register: captures one operation item and holds it until the walk
// stage consumes it.
// ----------------------------------------------------------------------------
module cr2q_in_reg import cr2q_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  op_t  op_i,
  input  logic take_i,
  output logic valid_o,
  output op_t  op_o
);

  logic valid_q, valid_d;
  op_t  op_q;
  logic load;

  // A new item may enter when the register is empty or is being drained.
  assign in_stall_o = valid_q && !take_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (load) begin
      op_q <= op_i;
    end
  end

  assign valid_o = valid_q;
  assign op_o    = op_q;

endmodule

// ===== rtl/cr2q_walk.sv =====
// ----------------------------------------------------------------------------
// cr2q_walk
// Walk stage: applies one alignment operation to the running reference
// distance and query count, and decides whether the read resolves here.
// ----------------------------------------------------------------------------
module cr2q_walk import cr2q_pkg::*; #(
  parameter int COORD_BITS = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic step_i,
  input  op_t  op_i,
  output logic res_valid_o,
  output res_t res_o
);

  // Saturation width of the query coordinate, limited to the output width.
  localparam int EffBits = (COORD_BITS > 32) ? 32 : ((COORD_BITS < 16) ? 16 : COORD_BITS);
  localparam int QW      = EffBits - 1;
  localparam logic [32:0]        QMaxU = (33'd1 << QW) - 33'd1;
  localparam logic signed [33:0] QMaxS = (34'sd1 <<< QW) - 34'sd1;
  localparam logic signed [33:0] QMinS = -QMaxS - 34'sd1;

  logic signed [31:0] dist_q, dist_d, dist_cur, dist_less;
  logic [QW-1:0]      qcnt_q, qcnt_d, qcnt_cur, qcnt_add;
  logic               done_q, done_d, done_cur;
  logic [32:0]        qsum;
  logic signed [33:0] qraw, qsat;
  logic               in_reach;
  logic               hit, del, skip;
  logic signed [31:0] qpos;

  // State seen by this item: a first operation restarts the read.
  always_comb begin
    if (op_i.first) begin
      dist_cur = 32'({1'b0, op_i.target}) - 32'({1'b0, op_i.start});
      qcnt_cur = '0;
      done_cur = 1'b0;
    end else begin
      dist_cur = dist_q;
      qcnt_cur = qcnt_q;
      done_cur = done_q;
    end
  end

  // Shared arithmetic: reach test, distance step, saturating query sums.
  always_comb begin
    in_reach  = $signed({dist_cur[31], dist_cur}) < $signed({5'b0, op_i.length});
    dist_less = dist_cur - $signed({4'b0, op_i.length});
    qsum      = 33'(qcnt_cur) + 33'(op_i.length);
    qcnt_add  = (qsum > QMaxU) ? '1 : qsum[QW-1:0];
    qraw      = $signed(34'(qcnt_cur)) + $signed({{2{dist_cur[31]}}, dist_cur});
    if (qraw > QMaxS) begin
      qsat = QMaxS;
    end else if (qraw < QMinS) begin
      qsat = QMinS;
    end else begin
      qsat = qraw;
    end
  end

  // Operation decode and next state.
  always_comb begin
    dist_d = dist_cur;
    qcnt_d = qcnt_cur;
    hit    = 1'b0;
    del    = 1'b0;
    skip   = 1'b0;
    qpos   = '0;
    if (!done_cur) begin
      case (op_i.code) inside
        OP_MATCH, OP_EQUAL, OP_DIFF: begin
          if (in_reach) begin
            hit  = 1'b1;
            qpos = qsat[31:0];
          end else begin
            dist_d = dist_less;
            qcnt_d = qcnt_add;
          end
        end
        OP_INS, OP_SOFT: begin
          qcnt_d = qcnt_add;
        end
        OP_DEL, OP_SKIP: begin
          if (in_reach) begin
            hit  = 1'b1;
            del  = 1'b1;
            skip = (op_i.code == OP_SKIP);
          end else begin
            dist_d = dist_less;
          end
        end
        default: begin
        end
      endcase
    end
    done_d = done_cur || hit || op_i.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_q <= '0;
      qcnt_q <= '0;
      done_q <= 1'b0;
    end else if (step_i) begin
      dist_q <= dist_d;
      qcnt_q <= qcnt_d;
      done_q <= done_d;
    end
  end

  // A read resolves at a hit or at its last operation, once only.
  assign res_valid_o       = step_i && !done_cur && (hit || op_i.last);
  assign res_o.query_pos   = qpos;
  assign res_o.is_deletion = del;
  assign res_o.is_ref_skip = skip;
  assign res_o.covered     = hit;

endmodule

// ===== rtl/cr2q_out_reg.sv =====
// ----------------------------------------------------------------------------
// cr2q_out_reg
// Result register: holds one resolved position until the receiver takes it.
// ----------------------------------------------------------------------------
module cr2q_out_reg import cr2q_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic load_i,
  input  res_t res_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output res_t res_o
);

  logic valid_q, valid_d;
  res_t res_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (valid_q && !out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

// ===== test/tb_cigar_ref_to_query_position_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cigar_ref_to_query_position_unit
// Streams alignment operations into the position unit and checks every
// resolved position against a cycle-free predictor of the read walk. A short
// directed table covers all operation codes, saturation and the odd read
// shapes; random reads with random pacing on both channels follow.
// ----------------------------------------------------------------------------
module tb_cigar_ref_to_query_position_unit;
  import cr2q_pkg::*;

  localparam int COORD_BITS = 32;
  localparam int EFF_BITS = (COORD_BITS > 32) ? 32 : ((COORD_BITS < 16) ? 16 : COORD_BITS);
  localparam longint Q_MAX = (64'sd1 <<< (EFF_BITS - 1)) - 64'sd1;
  localparam longint Q_MIN = -Q_MAX - 64'sd1;
  localparam longint D_MAX = 64'sd4294967295;
  localparam longint D_MIN = -64'sd4294967296;
  localparam int RANDOM_OPS = 500;
  localparam int LONG_HOLD_AT = 20;
  localparam int LONG_HOLD_CYCLES = 120;

  // Codes beyond the defined operations, which move neither distance nor query count.
  localparam logic [3:0] OP_SPARE_LO = 4'd9;
  localparam logic [3:0] OP_SPARE_HI = 4'd15;

  // One row of the directed table: an operation and, where given, its result.
  typedef struct packed {
    op_t  op;
    logic typed;
    logic yields;
    res_t res;
  } dir_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [3:0]         op_code_i = '0;
  logic [27:0]        op_length_i = '0;
  logic [30:0]        target_position_i = '0;
  logic [30:0]        read_start_i = '0;
  logic               first_op_i = 1'b0;
  logic               last_op_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [31:0] query_pos_o;
  logic               is_deletion_o;
  logic               is_ref_skip_o;
  logic               covered_o;

  // Predicted walk state.
  longint dist_left = 0;
  longint query_so_far = 0;
  bit     read_resolved = 1'b0;

  res_t     positions_due[$];
  dir_row_t dir_rows[$];
  int       errors = 0;
  int       results_seen = 0;
  int       pause_left = 0;
  bit       send_quiet = 1'b0;

  cigar_ref_to_query_position_unit #(
    .COORD_BITS(COORD_BITS)
  ) i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .op_code_i        (op_code_i),
    .op_length_i      (op_length_i),
    .target_position_i(target_position_i),
    .read_start_i     (read_start_i),
    .first_op_i       (first_op_i),
    .last_op_i        (last_op_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .query_pos_o      (query_pos_o),
    .is_deletion_o    (is_deletion_o),
    .is_ref_skip_o    (is_ref_skip_o),
    .covered_o        (covered_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic longint clamp(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Advances the predicted walk by one operation; returns 1 when a position
  // is resolved for the current read.
  function automatic bit resolve_op(op_t op, output res_t res);
    longint len;
    bit     hit;
    len = longint'(op.length);
    hit = 1'b0;
    res = '0;
    if (op.first) begin
      dist_left = longint'(op.target) - longint'(op.start);
      query_so_far = 0;
      read_resolved = 1'b0;
    end
    if (read_resolved) return 1'b0;
    case (op.code)
      OP_MATCH, OP_EQUAL, OP_DIFF: begin
        if (dist_left < len) begin
          hit = 1'b1;
          res.query_pos = 32'(clamp(query_so_far + dist_left, Q_MIN, Q_MAX));
        end else begin
          dist_left = clamp(dist_left - len, D_MIN, D_MAX);
          query_so_far = clamp(query_so_far + len, Q_MIN, Q_MAX);
        end
      end
      OP_INS, OP_SOFT: begin
        query_so_far = clamp(query_so_far + len, Q_MIN, Q_MAX);
      end
      OP_DEL, OP_SKIP: begin
        if (dist_left < len) begin
          hit = 1'b1;
          res.is_deletion = 1'b1;
          res.is_ref_skip = (op.code == OP_SKIP);
        end else begin
          dist_left = clamp(dist_left - len, D_MIN, D_MAX);
        end
      end
      default: ;
    endcase
    if (!hit && !op.last) return 1'b0;
    read_resolved = 1'b1;
    res.covered = hit;
    return 1'b1;
  endfunction

  function automatic dir_row_t mk_row(logic [3:0] code, logic [27:0] len, logic [30:0] tgt,
                                      logic [30:0] st, logic first, logic last, logic typed,
                                      logic yields, logic signed [31:0] qpos, logic del,
                                      logic skip, logic cov);
    dir_row_t r;
    r.op = '{code: code, length: len, target: tgt, start: st, first: first, last: last};
    r.typed = typed;
    r.yields = yields;
    r.res = '{query_pos: qpos, is_deletion: del, is_ref_skip: skip, covered: cov};
    return r;
  endfunction

  // Appends one row to the directed table.
  function automatic void add_row(dir_row_t r);
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  // Offers one item after a random gap and records its expected position
  // once it has been accepted.
  task automatic send_op(op_t op, bit typed, bit yields, res_t typed_res);
    int   gap;
    bit   due;
    res_t res;
    gap = send_quiet ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    op_code_i         <= op.code;
    op_length_i       <= op.length;
    target_position_i <= op.target;
    read_start_i      <= op.start;
    first_op_i        <= op.first;
    last_op_i         <= op.last;
    do @(posedge clk_i); while (in_stall_o);
    due = resolve_op(op, res);
    if (typed) begin
      if (yields) positions_due.insert(positions_due.size(), typed_res);
    end else if (due) begin
      positions_due.insert(positions_due.size(), res);
    end
  endtask

  // One read of random operations, mostly well formed with a target near
  // the read start; a few items carry broken first and last marks.
  task automatic send_random_read(ref int sent);
    int          n_ops;
    logic [30:0] st;
    logic [30:0] tgt;
    op_t         op;
    n_ops = $urandom_range(1, 8);
    st = ($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'($urandom_range(0, 65535));
    case ($urandom_range(0, 9))
      0:       tgt = 31'($urandom);
      1:       tgt = st - 31'($urandom_range(1, 50));
      default: tgt = st + 31'($urandom_range(0, 300));
    endcase
    for (int k = 0; k < n_ops; k++) begin
      op.code = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(OP_SPARE_LO, OP_SPARE_HI))
                                            : 4'($urandom_range(OP_MATCH, OP_DIFF));
      op.length = ($urandom_range(0, 15) == 0) ? 28'($urandom) : 28'($urandom_range(0, 80));
      op.first = (k == 0);
      op.last = (k == n_ops - 1);
      op.target = op.first ? tgt : 31'($urandom);
      op.start = op.first ? st : 31'($urandom);
      if ($urandom_range(0, 19) == 0) begin
        op.first = 1'($urandom_range(0, 1));
        op.last = 1'($urandom_range(0, 1));
      end
      send_quiet = (sent >= 100 && sent < 160);
      // Let the pipeline drain once in the middle of the run.
      if (sent == RANDOM_OPS / 2) begin
        in_valid_i <= 1'b0;
        do @(posedge clk_i); while (positions_due.size() != 0);
      end
      send_op(op, 1'b0, 1'b0, '0);
      sent++;
    end
  endtask

  // Result side pacing: a random stall after each item, one long hold-off
  // and a stretch with no stalls at all.
  always @(posedge clk_i) begin : result_pacing
    int pause_next;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen <= results_seen + 1;
      if (results_seen == LONG_HOLD_AT) begin
        pause_next = LONG_HOLD_CYCLES;
      end else if (results_seen >= 100 && results_seen < 140) begin
        pause_next = 0;
      end else begin
        pause_next = $urandom_range(0, 8);
      end
    end else begin
      pause_next = (pause_left != 0) ? pause_left - 1 : 0;
    end
    pause_left  <= pause_next;
    out_stall_i <= (pause_next != 0);
  end

  // Compares each accepted result with the oldest expected position.
  always @(posedge clk_i) begin : result_check
    res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (positions_due.size() == 0) begin
        $error("unexpected result: query_pos %0d, is_deletion %0b, is_ref_skip %0b, covered %0b",
               query_pos_o, is_deletion_o, is_ref_skip_o, covered_o);
        errors++;
      end else begin
        want = positions_due[0];
        positions_due.delete(0);
        if (want.query_pos !== query_pos_o) begin
          $error("query_pos: expected %0d, got %0d", want.query_pos, query_pos_o);
          errors++;
        end
        if (want.is_deletion !== is_deletion_o) begin
          $error("is_deletion: expected %0b, got %0b", want.is_deletion, is_deletion_o);
          errors++;
        end
        if (want.is_ref_skip !== is_ref_skip_o) begin
          $error("is_ref_skip: expected %0b, got %0b", want.is_ref_skip, is_ref_skip_o);
          errors++;
        end
        if (want.covered !== covered_o) begin
          $error("covered: expected %0b, got %0b", want.covered, covered_o);
          errors++;
        end
      end
    end
  end

  // Main sequence: reset, directed table, random reads, drain.
  initial begin : stimulus
    int sent;
    sent = 0;
    // Operation before any first mark continues from the reset state.
    add_row(mk_row(OP_MATCH, 28'd5, '0, '0, 0, 0, 1, 1, 0, 0, 0, 1));
    // Operations after a resolved read are ignored until the next first mark.
    add_row(mk_row(OP_INS, 28'd3, '0, '0, 0, 1, 1, 0, 0, 0, 0, 0));
    // Zero-length operations do not hold a target at distance zero.
    add_row(mk_row(OP_MATCH, 28'd0, 31'd100, 31'd100, 1, 0, 1, 0, 0, 0, 0, 0));
    add_row(mk_row(OP_DEL, 28'd0, '0, '0, 0, 0, 1, 0, 0, 0, 0, 0));
    add_row(mk_row(OP_SKIP, 28'd1, '0, '0, 0, 0, 1, 1, 0, 1, 1, 1));
    // Target before the read start, resolved in a zero-length match.
    add_row(mk_row(OP_INS, 28'd7, 31'd10, 31'd20, 1, 0, 0, 0, 0, 0, 0, 0));
    add_row(mk_row(OP_MATCH, 28'd0, '0, '0, 0, 0, 0, 0, 0, 0, 0, 0));
    // Single-operation read that misses its target.
    add_row(mk_row(OP_DEL, 28'd7, 31'd7, 31'd0, 1, 1, 1, 1, 0, 0, 0, 0));
    // Query count saturates; the match position saturates with it.
    add_row(mk_row(OP_SOFT, '1, 31'd5, 31'd0, 1, 0, 0, 0, 0, 0, 0, 0));
    for (int k = 0; k < 8; k++)
      add_row(mk_row(OP_INS, '1, '1, '1, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(mk_row(OP_HARD, '1, '0, '0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(mk_row(OP_PAD, '1, '0, '0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(mk_row(OP_SPARE_LO, '1, '0, '0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(mk_row(OP_DIFF, 28'd10, '0, '0, 0, 0, 1, 1, 32'sh7FFFFFFF, 0, 0, 1));
    add_row(mk_row(OP_SPARE_HI, '1, '1, '1, 0, 1, 1, 0, 0, 0, 0, 0));
    // Largest distance, longest operation, no hit.
    add_row(mk_row(OP_EQUAL, '1, '1, '0, 1, 1, 1, 1, 0, 0, 0, 0));
    // Most negative distance.
    add_row(mk_row(OP_SKIP, 28'd0, '0, '1, 1, 0, 1, 1, 0, 1, 1, 1));
    add_row(mk_row(OP_MATCH, '1, '0, '1, 1, 1, 0, 0, 0, 0, 0, 0));
    // Short read resolved inside its second match.
    add_row(mk_row(OP_MATCH, 28'd2, 31'd3, 31'd0, 1, 0, 0, 0, 0, 0, 0, 0));
    add_row(mk_row(OP_EQUAL, 28'd4, '0, '0, 0, 1, 0, 0, 0, 0, 0, 0));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i])
      send_op(dir_rows[i].op, dir_rows[i].typed, dir_rows[i].yields, dir_rows[i].res);

    while (sent < RANDOM_OPS) send_random_read(sent);

    in_valid_i <= 1'b0;
    while (positions_due.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin : watchdog
    #500000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
